FILE: rtl/core/bcd_pkg.sv
// shared types and constants for the bounded circular deque
`default_nettype none

package bcd_pkg;

  // default storage geometry
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths at the ports
  localparam int CAP_W   = 5;
  localparam int REQ_W   = 3;
  localparam int FIELD_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = REQ_W'(2);
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = REQ_W'(3);
  localparam logic [REQ_W-1:0] REQ_QUERY      = REQ_W'(4);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOAD
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/bcd_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module bcd_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bounded_circular_deque_top.sv
// bounded circular deque: ring of slots in ram with head, tail and count registers
// result path: a request beat starts the ram read of the front and rear slots after
//   the index update and moves the fsm to ST_LOAD, which loads the result register
// a new request is not taken in ST_LOAD or while a valid result is stalled, so the
//   deque does not take a request before the last one reaches the result register
// reset (rst, synchronous): deque empty, head and tail at slot zero, capacity 16;
//   slot contents are not cleared and are never read before being written
`default_nettype none

module bounded_circular_deque_top #(
  parameter int DEPTH      = bcd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bcd_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic        [bcd_pkg::CAP_W-1:0]   cfg_wr_data,
  // request channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic        [bcd_pkg::REQ_W-1:0]   req_type,
  input  wire logic signed [bcd_pkg::FIELD_W-1:0] data_value,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   accepted,
  output logic signed      [bcd_pkg::FIELD_W-1:0] front_value,
  output logic signed      [bcd_pkg::FIELD_W-1:0] rear_value,
  output logic                                   is_empty,
  output logic                                   is_full,
  output logic             [bcd_pkg::CAP_W-1:0]   entry_total
);

  import bcd_pkg::*;

  // slot index width and a wider scratch width for wrap compares
  localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW      = ((IW > CAP_W) ? IW : CAP_W) + 1;
  // capacity in use saturates at the store depth (and at the register range)
  localparam int CAP_LIM = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(CAP_LIM);

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx,
                                              input logic [CAP_W-1:0] cap);
    logic [XW-1:0] inc;
    inc = XW'(idx) + XW'(1);
    return (inc >= XW'(cap)) ? '0 : inc[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] idx,
                                              input logic [CAP_W-1:0] cap);
    logic [XW-1:0] dec;
    dec = (idx == '0) ? (XW'(cap) - XW'(1)) : (XW'(idx) - XW'(1));
    return dec[IW-1:0];
  endfunction

  // ring state
  logic [IW-1:0]    head;
  logic [IW-1:0]    tail;
  logic [CAP_W-1:0] count;
  logic [CAP_W-1:0] capacity;
  state_t           state;
  state_t           state_next;

  // values computed for the request at the input
  logic [IW-1:0]         head_next;
  logic [IW-1:0]         tail_next;
  logic [CAP_W-1:0]      count_next;
  logic [CAP_W-1:0]      cap_use;
  logic                  ok;
  logic                  wr_req;
  logic [IW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [IW-1:0]         rd_front_addr;
  logic [IW-1:0]         rd_rear_addr;
  logic                  in_beat;
  logic                  load_en;

  // held across the ram read cycle
  logic                  ok_q;
  logic                  fwd_front;
  logic                  fwd_rear;
  logic [DATA_WIDTH-1:0] wr_data_q;
  logic [DATA_WIDTH-1:0] rd_front_data;
  logic [DATA_WIDTH-1:0] rd_rear_data;
  logic [DATA_WIDTH-1:0] front_sel;
  logic [DATA_WIDTH-1:0] rear_sel;

  assign cap_use = (capacity > CAP_MAX) ? CAP_MAX : capacity;
  assign in_beat = in_valid && !in_stall;
  // sign-extend or truncate the request value to the slot width
  assign wr_data = DATA_WIDTH'(data_value);

  // request decode: index updates, slot write and acceptance
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    wr_req     = 1'b0;
    wr_addr    = tail;
    ok         = 1'b1;
    unique case (req_type)
      REQ_PUSH_FRONT: begin
        if (count < cap_use) begin
          head_next  = ring_prev(head, cap_use);
          wr_addr    = head_next;
          wr_req     = 1'b1;
          count_next = count + CAP_W'(1);
        end else begin
          ok = 1'b0;
        end
      end
      REQ_PUSH_BACK: begin
        if (count < cap_use) begin
          wr_addr    = tail;
          wr_req     = 1'b1;
          tail_next  = ring_next(tail, cap_use);
          count_next = count + CAP_W'(1);
        end else begin
          ok = 1'b0;
        end
      end
      REQ_POP_FRONT: begin
        if (count != '0 && cap_use != '0) begin
          head_next  = ring_next(head, cap_use);
          count_next = count - CAP_W'(1);
        end else begin
          ok = 1'b0;
        end
      end
      REQ_POP_BACK: begin
        if (count != '0 && cap_use != '0) begin
          tail_next  = ring_prev(tail, cap_use);
          count_next = count - CAP_W'(1);
        end else begin
          ok = 1'b0;
        end
      end
      default: begin
        // query and unused codes leave the ring alone
        ok = 1'b1;
      end
    endcase
    // front and rear slots after the update
    rd_front_addr = head_next;
    rd_rear_addr  = ring_prev(tail_next, cap_use);
  end

  // two copies of the slot store, one read port each for front and rear
  bcd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_front_ram (
    .clk     (clk),
    .wr_en   (in_beat && wr_req),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_beat),
    .rd_addr (rd_front_addr),
    .rd_data (rd_front_data)
  );

  bcd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_rear_ram (
    .clk     (clk),
    .wr_en   (in_beat && wr_req),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_beat),
    .rd_addr (rd_rear_addr),
    .rd_data (rd_rear_data)
  );

  // next state
  always_comb begin
    unique case (state)
      ST_IDLE: state_next = in_beat ? ST_LOAD : ST_IDLE;
      ST_LOAD: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // fsm outputs: take a request only when idle and the result register can free up
  always_comb begin
    unique case (state)
      ST_IDLE: begin
        in_stall = out_valid && out_stall;
        load_en  = 1'b0;
      end
      ST_LOAD: begin
        in_stall = 1'b1;
        load_en  = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
        load_en  = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      capacity <= CAP_RESET;
      state    <= ST_IDLE;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        // new capacity rebuilds the ring empty
        capacity <= cfg_wr_data;
        head     <= '0;
        tail     <= '0;
        count    <= '0;
      end else if (in_beat) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
  end

  // bypass: a slot written on the same edge it is read returns the new value
  always_ff @(posedge clk) begin
    if (in_beat) begin
      ok_q      <= ok;
      wr_data_q <= wr_data;
      fwd_front <= wr_req && (wr_addr == rd_front_addr);
      fwd_rear  <= wr_req && (wr_addr == rd_rear_addr);
    end
  end

  assign front_sel = fwd_front ? wr_data_q : rd_front_data;
  assign rear_sel  = fwd_rear  ? wr_data_q : rd_rear_data;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      accepted    <= ok_q;
      is_empty    <= (count == '0);
      is_full     <= (count == cap_use);
      entry_total <= count;
      // empty deque reports all ones on both ends
      front_value <= (count == '0) ? '1 : FIELD_W'(front_sel);
      rear_value  <= (count == '0) ? '1 : FIELD_W'(rear_sel);
    end
  end

  // the ring never holds more entries than the capacity in use
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cap_use)
    else $error("entry count above capacity in use");

  // a result only appears after the ram read cycle
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_LOAD))
    else $error("result valid without a preceding load cycle");

  // empty results carry all ones on both ends
  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> (front_value == '1 && rear_value == '1 && entry_total == '0))
    else $error("empty result with stale end values");

  // a refused push only happens on a full deque
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    (in_beat && !cfg_wr_en && !ok &&
     (req_type == REQ_PUSH_FRONT || req_type == REQ_PUSH_BACK)) |-> (count == cap_use))
    else $error("push refused while space remains");

endmodule

`default_nettype wire
